// ----- sv/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define TFC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/tfc_pkg.sv -----
// shared types, constants and codes of the t1 tissue classifier
package tfc_pkg;

    // histogram defaults
    localparam int BINS_DEF      = 256;
    localparam int BIN_WIDTH_DEF = 20;

    // configuration register layout
    localparam int CFG_W      = 16;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [2:0] REG_CUTOFF       = 3'd0;
    localparam logic [2:0] REG_WM_LOWER     = 3'd1;
    localparam logic [2:0] REG_WM_UPPER     = 3'd2;
    localparam logic [2:0] REG_WM_GM_CENTER = 3'd3;
    localparam logic [2:0] REG_GM_LOWER     = 3'd4;
    localparam logic [2:0] REG_CSF_LOWER    = 3'd5;
    localparam logic [2:0] REG_GM_UPPER     = 3'd6;
    localparam logic [2:0] REG_CSF_UPPER    = 3'd7;

    localparam logic [CFG_W-1:0] RST_CUTOFF       = 16'd0;
    localparam logic [CFG_W-1:0] RST_WM_LOWER     = 16'd200;
    localparam logic [CFG_W-1:0] RST_WM_UPPER     = 16'd1300;
    localparam logic [CFG_W-1:0] RST_WM_GM_CENTER = 16'd1350;
    localparam logic [CFG_W-1:0] RST_GM_LOWER     = 16'd1400;
    localparam logic [CFG_W-1:0] RST_CSF_LOWER    = 16'd1900;
    localparam logic [CFG_W-1:0] RST_GM_UPPER     = 16'd2200;
    localparam logic [CFG_W-1:0] RST_CSF_UPPER    = 16'd5000;

    // serial divider widths
    localparam int DIV_NUM_W = 37;
    localparam int DIV_DEN_W = 19;

    // fixed point
    localparam int PROB_W    = 17;
    localparam int EXP_TERMS = 12;

    typedef struct packed {
        logic [CFG_W-1:0] cutoff;
        logic [CFG_W-1:0] wm_lower;
        logic [CFG_W-1:0] wm_upper;
        logic [CFG_W-1:0] wm_gm_center;
        logic [CFG_W-1:0] gm_lower;
        logic [CFG_W-1:0] csf_lower;
        logic [CFG_W-1:0] gm_upper;
        logic [CFG_W-1:0] csf_upper;
    } cfg_t;

    typedef enum logic [2:0] {
        BAND_NONE,
        BAND_WM,
        BAND_WG,
        BAND_GM,
        BAND_GC,
        BAND_CSF
    } band_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_A,
        DIV_TERM,
        DIV_P
    } div_sel_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RD_CAP,
        S_BIN_CHK,
        S_HIST_WR,
        S_BAND,
        S_A_WAIT,
        S_MUL,
        S_TDIV,
        S_TWAIT,
        S_VLOAD,
        S_SQ,
        S_P,
        S_P_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     latch_in;
        logic     clr_step;
        logic     rd_req;
        logic     rd_cap;
        logic     div_start;
        div_sel_t div_sel;
        logic     set_oor;
        logic     hist_rd;
        logic     hist_wr;
        logic     band_set;
        logic     a_load;
        logic     term_mul;
        logic     term_load;
        logic     v_load;
        logic     sq_step;
        logic     p_load;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  mode;
        logic  below_cut;
        logic  t_zero;
        logic  bin_oor;
        band_t band;
        logic  div_done;
        logic  n_last;
        logic  k_last;
        logic  clr_last;
    } ctrl_stat_t;

endpackage

// ----- sv/t1_tissue_fuzzy_classifier.sv -----
// top level of the t1 tissue fuzzy classifier with t1 histogram
//
// channel   direction  handshake              payload
// config    in/out     psel/penable/pwrite    paddr, pwdata, prdata (8 x 16-bit registers)
// input     in         in_valid / in_ready    mode, t1_value, bin_index
// result    out        out_valid / out_ready  wm_prob, gm_prob, csf_prob, bin_count,
//                                             bin_out_of_range
//
// one transaction in flight; a transition uses the shared serial divider for the sigmoid
// argument, each of the twelve series terms and the final ratio
// after reset a clearing pass zeroes the histogram; no input is taken
// a result waits in the output register; the next transaction is taken meanwhile and
// holds in its last step until the output register frees
module t1_tissue_fuzzy_classifier #(
    parameter int BINS      = tfc_pkg::BINS_DEF,
    parameter int BIN_WIDTH = tfc_pkg::BIN_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tfc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tfc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [15:0]                   t1_value,
    input  logic [7:0]                    bin_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tfc_pkg::PROB_W-1:0]    wm_prob,
    output logic [tfc_pkg::PROB_W-1:0]    gm_prob,
    output logic [tfc_pkg::PROB_W-1:0]    csf_prob,
    output logic [31:0]                   bin_count,
    output logic                          bin_out_of_range
);
    import tfc_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // configuration registers
    tfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    tfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and storage
    tfc_datapath #(
        .BINS      (BINS),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .stat             (stat),
        .mode             (mode),
        .t1_value         (t1_value),
        .bin_index        (bin_index),
        .wm_prob          (wm_prob),
        .gm_prob          (gm_prob),
        .csf_prob         (csf_prob),
        .bin_count        (bin_count),
        .bin_out_of_range (bin_out_of_range)
    );

endmodule

// ----- sv/tfc_regs.sv -----
// apb configuration registers of the classifier
module tfc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tfc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tfc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output tfc_pkg::cfg_t                 cfg
);
    import tfc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;
    logic [CFG_W-1:0] rd_val;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cutoff       <= RST_CUTOFF;
            cfg_reg.wm_lower     <= RST_WM_LOWER;
            cfg_reg.wm_upper     <= RST_WM_UPPER;
            cfg_reg.wm_gm_center <= RST_WM_GM_CENTER;
            cfg_reg.gm_lower     <= RST_GM_LOWER;
            cfg_reg.csf_lower    <= RST_CSF_LOWER;
            cfg_reg.gm_upper     <= RST_GM_UPPER;
            cfg_reg.csf_upper    <= RST_CSF_UPPER;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CUTOFF:       cfg_reg.cutoff       <= pwdata[CFG_W-1:0];
                REG_WM_LOWER:     cfg_reg.wm_lower     <= pwdata[CFG_W-1:0];
                REG_WM_UPPER:     cfg_reg.wm_upper     <= pwdata[CFG_W-1:0];
                REG_WM_GM_CENTER: cfg_reg.wm_gm_center <= pwdata[CFG_W-1:0];
                REG_GM_LOWER:     cfg_reg.gm_lower     <= pwdata[CFG_W-1:0];
                REG_CSF_LOWER:    cfg_reg.csf_lower    <= pwdata[CFG_W-1:0];
                REG_GM_UPPER:     cfg_reg.gm_upper     <= pwdata[CFG_W-1:0];
                REG_CSF_UPPER:    cfg_reg.csf_upper    <= pwdata[CFG_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (idx)
            REG_CUTOFF:       rd_val = cfg_reg.cutoff;
            REG_WM_LOWER:     rd_val = cfg_reg.wm_lower;
            REG_WM_UPPER:     rd_val = cfg_reg.wm_upper;
            REG_WM_GM_CENTER: rd_val = cfg_reg.wm_gm_center;
            REG_GM_LOWER:     rd_val = cfg_reg.gm_lower;
            REG_CSF_LOWER:    rd_val = cfg_reg.csf_lower;
            REG_GM_UPPER:     rd_val = cfg_reg.gm_upper;
            REG_CSF_UPPER:    rd_val = cfg_reg.csf_upper;
            default:          rd_val = '0;
        endcase
        prdata = PDATA_W'(rd_val);
    end

endmodule

// ----- sv/tfc_div.sv -----
// restoring serial divider, one quotient bit per cycle
module tfc_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tfc_pkg::DIV_NUM_W-1:0]   num,
    input  logic [tfc_pkg::DIV_DEN_W-1:0]   den,
    output logic [tfc_pkg::DIV_NUM_W-1:0]   quo,
    output logic                            done
);
    import tfc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, q_reg[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // next step of the shift and subtract
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIV_NUM_W-2:0], ge};
            rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and quotient registers
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

// ----- sv/tfc_datapath.sv -----
// datapath: band decode, sigmoid arithmetic, histogram memory, result registers
module tfc_datapath #(
    parameter int BINS      = tfc_pkg::BINS_DEF,
    parameter int BIN_WIDTH = tfc_pkg::BIN_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tfc_pkg::cfg_t                 cfg,
    input  tfc_pkg::ctrl_cmd_t            cmd,
    output tfc_pkg::ctrl_stat_t           stat,
    input  logic                          mode,
    input  logic [15:0]                   t1_value,
    input  logic [7:0]                    bin_index,
    output logic [tfc_pkg::PROB_W-1:0]    wm_prob,
    output logic [tfc_pkg::PROB_W-1:0]    gm_prob,
    output logic [tfc_pkg::PROB_W-1:0]    csf_prob,
    output logic [31:0]                   bin_count,
    output logic                          bin_out_of_range
);
    import tfc_pkg::*;

    localparam int AW = $clog2(BINS);
    localparam logic [PROB_W-1:0] ONE = PROB_W'(65536);
    localparam logic [20:0] A_MAX = 21'h100000;
    // reciprocal of the bin width, exact floor for any 16-bit t1
    localparam int BIN_SH = 16 + $clog2(BIN_WIDTH);
    localparam longint unsigned BIN_MUL =
        ((64'd1 << BIN_SH) + 64'(BIN_WIDTH) - 64'd1) / 64'(BIN_WIDTH);

    // latched transaction
    logic        mode_reg;
    logic [15:0] t_reg;
    logic [7:0]  idx_reg;

    // histogram memory
    logic [31:0]   hist_mem [BINS];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data;
    logic          we, re;
    logic          idx_ok;
    logic [33:0]   bin_prod;
    logic [15:0]   bin;

    // sigmoid work registers
    logic [20:0] a_reg;
    logic [31:0] term_reg;
    logic [31:0] prod_reg;
    logic [33:0] pos_reg, neg_reg;
    logic [3:0]  n_reg;
    logic [33:0] v_reg;
    logic [1:0]  k_reg;

    // result work registers
    logic [PROB_W-1:0] res_wm, res_gm, res_csf;
    logic [31:0]       res_count;
    logic              res_oor;

    // divider
    logic [DIV_NUM_W-1:0] div_num, div_q;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;

    band_t              band;
    logic signed [18:0] d;
    logic [17:0]        ad;
    logic [19:0]        ad5;
    logic [15:0]        w, w_eff;
    logic [DIV_DEN_W-1:0] den_a;
    logic [34:0]        v_rnd;
    logic [16:0]        y;
    logic [17:0]        den_p;
    logic [52:0]        prod_full;
    logic [67:0]        sq;
    logic [PROB_W-1:0]  p, p_lower, p_upper;

    // band decode, the later band wins
    always_comb
    begin
        band = BAND_NONE;
        if (t_reg > cfg.wm_lower && t_reg < cfg.wm_upper)    band = BAND_WM;
        if (t_reg > cfg.wm_upper && t_reg < cfg.gm_lower)    band = BAND_WG;
        if (t_reg > cfg.gm_lower && t_reg < cfg.csf_lower)   band = BAND_GM;
        if (t_reg > cfg.csf_lower && t_reg < cfg.gm_upper)   band = BAND_GC;
        if (t_reg > cfg.gm_upper && t_reg < cfg.csf_upper)   band = BAND_CSF;
    end

    // transition offset and width
    always_comb
    begin
        if (band == BAND_GC)
        begin
            d = $signed({2'b0, t_reg, 1'b0}) - $signed({3'b0, cfg.csf_lower})
                - $signed({3'b0, cfg.gm_upper});
            w = cfg.gm_upper - cfg.csf_lower;
        end
        else
        begin
            d = $signed({2'b0, t_reg, 1'b0}) - $signed({2'b0, cfg.wm_gm_center, 1'b0});
            w = cfg.gm_lower - cfg.wm_upper;
        end
        ad    = d[18] ? 18'(-d) : 18'(d);
        ad5   = 20'(ad) * 20'd5;
        w_eff = (w == '0) ? 16'd1 : w;
        den_a = DIV_DEN_W'(w_eff) * DIV_DEN_W'(7);
    end

    // histogram bin by reciprocal multiplication
    assign bin_prod = 34'(t_reg) * 34'(BIN_MUL);
    assign bin      = 16'(bin_prod >> BIN_SH);

    // rounded q16 exponential and its denominator
    assign v_rnd = 35'(v_reg) + 35'(16384);
    assign y     = v_rnd[31:15];
    assign den_p = 18'(y) + 18'd65536;

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_IDLE:
            begin
                div_num = '0;
                div_den = DIV_DEN_W'(1);
            end
            DIV_A:
            begin
                div_num = DIV_NUM_W'({ad5, 16'b0}) + DIV_NUM_W'(den_a[DIV_DEN_W-1:1]);
                div_den = den_a;
            end
            DIV_TERM:
            begin
                div_num = DIV_NUM_W'(prod_reg);
                div_den = DIV_DEN_W'(n_reg);
            end
            DIV_P:
            begin
                div_num = DIV_NUM_W'({y, 16'b0}) + DIV_NUM_W'(den_p[17:1]);
                div_den = DIV_DEN_W'(den_p);
            end
            default:
            begin
                div_num = '0;
                div_den = DIV_DEN_W'(1);
            end
        endcase
    end

    tfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q),
        .done  (div_done)
    );

    // arithmetic of the series and squarings
    assign prod_full = 53'(term_reg) * 53'(a_reg);
    assign sq        = 68'(v_reg) * 68'(v_reg) + 68'(32'h4000_0000);

    // membership split
    assign p       = div_q[PROB_W-1:0];
    assign p_lower = d[18] ? ONE - p : p;
    assign p_upper = ONE - p_lower;

    // histogram access
    assign idx_ok  = 32'(idx_reg) < 32'(BINS);
    assign we      = cmd.clr_step || cmd.hist_wr;
    assign re      = cmd.rd_req || cmd.hist_rd;
    assign wr_addr = cmd.clr_step ? clr_cnt_reg : AW'(bin);
    assign rd_addr = mode_reg ? AW'(idx_reg) : AW'(bin);
    assign wr_data = cmd.clr_step ? 32'd0 :
                     (rd_data_reg == 32'hFFFF_FFFF) ? rd_data_reg : rd_data_reg + 32'd1;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.a_load)
            begin
                n_reg <= 4'd1;
            end
            else if (cmd.term_load)
            begin
                n_reg <= n_reg + 4'd1;
            end
            if (cmd.v_load)
            begin
                k_reg <= '0;
            end
            else if (cmd.sq_step)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    // transaction, work and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg  <= mode;
            t_reg     <= t1_value;
            idx_reg   <= bin_index;
            res_wm    <= '0;
            res_gm    <= '0;
            res_csf   <= '0;
            res_count <= '0;
            res_oor   <= 1'b0;
        end
        if (cmd.rd_cap)
        begin
            res_count <= idx_ok ? rd_data_reg : 32'd0;
        end
        if (cmd.set_oor)
        begin
            res_oor <= 1'b1;
        end
        if (cmd.band_set)
        begin
            res_wm  <= (band == BAND_WM)  ? ONE : '0;
            res_gm  <= (band == BAND_GM)  ? ONE : '0;
            res_csf <= (band == BAND_CSF) ? ONE : '0;
        end
        if (cmd.a_load)
        begin
            a_reg    <= (div_q > DIV_NUM_W'(A_MAX)) ? A_MAX : div_q[20:0];
            term_reg <= 32'h8000_0000;
            pos_reg  <= 34'h0_8000_0000;
            neg_reg  <= '0;
        end
        if (cmd.term_mul)
        begin
            prod_reg <= prod_full[51:20];
        end
        if (cmd.term_load)
        begin
            term_reg <= div_q[31:0];
            if (n_reg[0])
            begin
                neg_reg <= neg_reg + 34'(div_q[31:0]);
            end
            else
            begin
                pos_reg <= pos_reg + 34'(div_q[31:0]);
            end
        end
        if (cmd.v_load)
        begin
            v_reg <= (pos_reg > neg_reg) ? pos_reg - neg_reg : '0;
        end
        if (cmd.sq_step)
        begin
            v_reg <= sq[64:31];
        end
        if (cmd.p_load)
        begin
            if (band == BAND_GC)
            begin
                res_wm  <= '0;
                res_gm  <= p_lower;
                res_csf <= p_upper;
            end
            else
            begin
                res_wm  <= p_lower;
                res_gm  <= p_upper;
                res_csf <= '0;
            end
        end
        if (cmd.out_load)
        begin
            wm_prob          <= res_wm;
            gm_prob          <= res_gm;
            csf_prob         <= res_csf;
            bin_count        <= res_count;
            bin_out_of_range <= res_oor;
        end
    end

    // status to the controller
    assign stat.mode      = mode_reg;
    assign stat.below_cut = t_reg < cfg.cutoff;
    assign stat.t_zero    = t_reg == '0;
    assign stat.bin_oor   = 32'(bin) >= 32'(BINS);
    assign stat.band      = band;
    assign stat.div_done  = div_done;
    assign stat.n_last    = n_reg == 4'(EXP_TERMS);
    assign stat.k_last    = k_reg == 2'd3;
    assign stat.clr_last  = clr_cnt_reg == AW'(BINS - 1);

endmodule

// ----- sv/tfc_ctrl.sv -----
// controller state machine sequencing one transaction at a time
module tfc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tfc_pkg::ctrl_stat_t   stat,
    output tfc_pkg::ctrl_cmd_t    cmd
);
    import tfc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_IDLE;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.mode)
                begin
                    cmd.rd_req = 1'b1;
                    state_next = S_RD_CAP;
                end
                else if (stat.below_cut)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.t_zero)
                begin
                    state_next = S_BAND;
                end
                else
                begin
                    state_next = S_BIN_CHK;
                end
            end
            S_RD_CAP:
            begin
                cmd.rd_cap = 1'b1;
                state_next = S_FINISH;
            end
            S_BIN_CHK:
            begin
                if (stat.bin_oor)
                begin
                    cmd.set_oor = 1'b1;
                    state_next  = S_BAND;
                end
                else
                begin
                    cmd.hist_rd = 1'b1;
                    state_next  = S_HIST_WR;
                end
            end
            S_HIST_WR:
            begin
                cmd.hist_wr = 1'b1;
                state_next  = S_BAND;
            end
            S_BAND:
            begin
                cmd.band_set = 1'b1;
                if (stat.band == BAND_WG || stat.band == BAND_GC)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_A;
                    state_next    = S_A_WAIT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_A_WAIT:
            begin
                cmd.div_sel = DIV_A;
                if (stat.div_done)
                begin
                    cmd.a_load = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.term_mul = 1'b1;
                state_next   = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TERM;
                state_next    = S_TWAIT;
            end
            S_TWAIT:
            begin
                cmd.div_sel = DIV_TERM;
                if (stat.div_done)
                begin
                    cmd.term_load = 1'b1;
                    state_next    = stat.n_last ? S_VLOAD : S_MUL;
                end
            end
            S_VLOAD:
            begin
                cmd.v_load = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (stat.k_last)
                begin
                    state_next = S_P;
                end
            end
            S_P:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_P;
                state_next    = S_P_WAIT;
            end
            S_P_WAIT:
            begin
                cmd.div_sel = DIV_P;
                if (stat.div_done)
                begin
                    cmd.p_load = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/tfc_checker.sv -----
// port-level checker of the classifier and its bind
`include "assert_macros.svh"

module tfc_sva (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tfc_pkg::PROB_W-1:0]    wm_prob,
    input logic [tfc_pkg::PROB_W-1:0]    gm_prob,
    input logic [tfc_pkg::PROB_W-1:0]    csf_prob,
    input logic [31:0]                   bin_count,
    input logic                          bin_out_of_range
);
    import tfc_pkg::*;

    logic [PROB_W+1:0]       prob_sum;
    logic [3*PROB_W+32:0]    res_bus;
    logic                    out_stall;
    logic                    read_mix;

    assign prob_sum = (PROB_W+2)'(wm_prob) + (PROB_W+2)'(gm_prob) + (PROB_W+2)'(csf_prob);
    assign res_bus   = {wm_prob, gm_prob, csf_prob, bin_count, bin_out_of_range};
    assign out_stall = out_valid && !out_ready;
    assign read_mix  = bin_count != 32'd0 && (bin_out_of_range || prob_sum != '0);

    // a stalled result holds
    `TFC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(res_bus), "stalled result changed")

    // one transaction at a time
    `TFC_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second transaction taken")

    // memberships never exceed one in total
    `TFC_ASSERT_NEVER(a_prob_sum, out_valid && prob_sum > (PROB_W+2)'(65536), "sum above one")

    // a bin count comes only with zero memberships and no range flag
    `TFC_ASSERT_NEVER(a_read_mix, out_valid && read_mix, "bin count mixed with classify fields")

endmodule

bind t1_tissue_fuzzy_classifier tfc_sva u_chk (.*);

// ----- verif/tfc_checker.sv -----
// checker for the t1 tissue classifier: watches the channels, predicts and compares results
`timescale 1ns / 1ps

module tfc_checker
    import tfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                mode,
    input  logic [15:0]         t1_value,
    input  logic [7:0]          bin_index,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [PROB_W-1:0]   wm_prob,
    input  logic [PROB_W-1:0]   gm_prob,
    input  logic [PROB_W-1:0]   csf_prob,
    input  logic [31:0]         bin_count,
    input  logic                bin_out_of_range,
    output int                  errors,
    output int                  pending
);

    localparam int        N_BINS  = BINS_DEF;
    localparam int        BIN_W   = BIN_WIDTH_DEF;
    localparam longint unsigned ONE_Q16 = 64'd65536;

    typedef struct packed {
        logic [PROB_W-1:0] wm;
        logic [PROB_W-1:0] gm;
        logic [PROB_W-1:0] csf;
        logic [31:0]       count;
        logic              oor;
    } tissue_result_t;

    cfg_t            thresholds;
    logic [31:0]     bin_counts [N_BINS];
    tissue_result_t  expected_results [$];

    // e^-a, a in q16 up to 16.0, via series of e^-(a/16) then four squarings
    function automatic longint unsigned exp_neg_q16(longint unsigned a);
        longint unsigned term, pos, neg, v;
        term = 64'h8000_0000;
        pos  = 64'h8000_0000;
        neg  = 0;
        for (int n = 1; n <= EXP_TERMS; n++)
        begin
            term = ((term * a) >> 20) / n;
            if (n % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        v = (pos > neg) ? pos - neg : 0;
        for (int k = 0; k < 4; k++)
            v = (v * v + (64'd1 << 30)) >> 31;
        return (v + (64'd1 << 14)) >> 15;
    endfunction

    // logistic split of one transition band between lower and upper tissue
    function automatic void split_membership(input longint d, input longint unsigned w,
                                             output logic [PROB_W-1:0] lower,
                                             output logic [PROB_W-1:0] upper);
        longint unsigned ad, den, a, y, p;
        ad  = (d < 0) ? longint'(-d) : longint'(d);
        den = 7 * ((w != 0) ? w : 1);
        a   = (5 * ad * ONE_Q16 + den / 2) / den;
        if (a > (64'd16 << 16))
            a = 64'd16 << 16;
        y = exp_neg_q16(a);
        p = (y * ONE_Q16 + (ONE_Q16 + y) / 2) / (ONE_Q16 + y);
        if (d >= 0)
        begin
            lower = PROB_W'(p);
            upper = PROB_W'(ONE_Q16 - p);
        end
        else
        begin
            lower = PROB_W'(ONE_Q16 - p);
            upper = PROB_W'(p);
        end
    endfunction

    // classify one voxel or read a bin, updating the histogram copy
    function automatic tissue_result_t classify_voxel(logic rd, logic [15:0] t,
                                                      logic [7:0] idx);
        tissue_result_t r;
        longint         t2, d;
        int unsigned    bin;
        r  = '0;
        t2 = 2 * longint'(t);
        if (rd)
        begin
            if (idx < N_BINS)
                r.count = bin_counts[idx];
        end
        else if (t >= thresholds.cutoff)
        begin
            if (t > 0)
            begin
                bin = t / BIN_W;
                if (bin < N_BINS)
                begin
                    if (bin_counts[bin] != 32'hFFFF_FFFF)
                        bin_counts[bin]++;
                end
                else
                    r.oor = 1'b1;
            end
            if (t > thresholds.wm_lower && t < thresholds.wm_upper)
            begin
                r.wm = PROB_W'(ONE_Q16); r.gm = '0; r.csf = '0;
            end
            if (t > thresholds.wm_upper && t < thresholds.gm_lower)
            begin
                d = t2 - 2 * longint'(thresholds.wm_gm_center);
                split_membership(d, thresholds.gm_lower - thresholds.wm_upper, r.wm, r.gm);
                r.csf = '0;
            end
            if (t > thresholds.gm_lower && t < thresholds.csf_lower)
            begin
                r.wm = '0; r.gm = PROB_W'(ONE_Q16); r.csf = '0;
            end
            if (t > thresholds.csf_lower && t < thresholds.gm_upper)
            begin
                d = t2 - longint'(thresholds.csf_lower) - longint'(thresholds.gm_upper);
                r.wm = '0;
                split_membership(d, thresholds.gm_upper - thresholds.csf_lower, r.gm, r.csf);
            end
            if (t > thresholds.gm_upper && t < thresholds.csf_upper)
            begin
                r.wm = '0; r.gm = '0; r.csf = PROB_W'(ONE_Q16);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tissue_result_t exp_r;
        if (!rst_n)
        begin
            thresholds <= '{RST_CUTOFF, RST_WM_LOWER, RST_WM_UPPER, RST_WM_GM_CENTER,
                            RST_GM_LOWER, RST_CSF_LOWER, RST_GM_UPPER, RST_CSF_UPPER};
            for (int i = 0; i < N_BINS; i++)
                bin_counts[i] = '0;
            expected_results.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CUTOFF:       thresholds.cutoff       <= pwdata[15:0];
                    REG_WM_LOWER:     thresholds.wm_lower     <= pwdata[15:0];
                    REG_WM_UPPER:     thresholds.wm_upper     <= pwdata[15:0];
                    REG_WM_GM_CENTER: thresholds.wm_gm_center <= pwdata[15:0];
                    REG_GM_LOWER:     thresholds.gm_lower     <= pwdata[15:0];
                    REG_CSF_LOWER:    thresholds.csf_lower    <= pwdata[15:0];
                    REG_GM_UPPER:     thresholds.gm_upper     <= pwdata[15:0];
                    REG_CSF_UPPER:    thresholds.csf_upper    <= pwdata[15:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.wm !== wm_prob)
                        $error("wm_prob expected %0d actual %0d", exp_r.wm, wm_prob);
                    if (exp_r.gm !== gm_prob)
                        $error("gm_prob expected %0d actual %0d", exp_r.gm, gm_prob);
                    if (exp_r.csf !== csf_prob)
                        $error("csf_prob expected %0d actual %0d", exp_r.csf, csf_prob);
                    if (exp_r.count !== bin_count)
                        $error("bin_count expected %0d actual %0d", exp_r.count, bin_count);
                    if (exp_r.oor !== bin_out_of_range)
                        $error("bin_out_of_range expected %0d actual %0d",
                               exp_r.oor, bin_out_of_range);
                    if (exp_r !== {wm_prob, gm_prob, csf_prob, bin_count, bin_out_of_range})
                        errors <= errors + 1;
                end
            end
            // input transaction
            if (in_valid && in_ready)
                expected_results.push_back(classify_voxel(mode, t1_value, bin_index));
            pending <= expected_results.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// top of the t1 tissue classifier testbench: stimulus, receiver, watchdog and verdict
`timescale 1ns / 1ps

module tb_top;
    import tfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int PHASE_ITEMS    = 220;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0, in_ready;
    logic               mode = 1'b0;
    logic [15:0]        t1_value = '0;
    logic [7:0]         bin_index = '0;
    logic               out_valid, out_ready = 1'b0;
    logic [PROB_W-1:0]  wm_prob, gm_prob, csf_prob;
    logic [31:0]        bin_count;
    logic               bin_out_of_range;
    int                 errors, pending;

    // stimulus-side copy of the thresholds, used to aim values at band edges
    logic [15:0]        cur_thr [8];
    logic               quiet = 1'b0;
    logic               hold_req = 1'b0;
    logic               hold_done = 1'b0;
    int                 hold_cnt = 0;
    int                 idle_cycles = 0;

    always #10 clk = ~clk;

    t1_tissue_fuzzy_classifier i_dut (.*);

    tfc_checker i_checker (.*);

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= 14);
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_thr[idx] = value;
    endtask

    // one input transaction; returns at the accepting edge with valid still high
    task automatic send_voxel(logic rd, logic [15:0] t, logic [7:0] idx);
        if (!quiet && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= rd;
        t1_value  <= t;
        bin_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop sending and let every expected result drain
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_thresholds(logic [15:0] c, logic [15:0] v [7]);
        reg_write(REG_CUTOFF, c);
        reg_write(REG_WM_LOWER, v[0]);
        reg_write(REG_WM_UPPER, v[1]);
        reg_write(REG_WM_GM_CENTER, v[2]);
        reg_write(REG_GM_LOWER, v[3]);
        reg_write(REG_CSF_LOWER, v[4]);
        reg_write(REG_GM_UPPER, v[5]);
        reg_write(REG_CSF_UPPER, v[6]);
    endtask

    // random transactions: reads, values near thresholds, values anywhere
    task automatic random_voxels(int n);
        int          pick;
        logic [15:0] t;
        for (int i = 0; i < n; i++)
        begin
            quiet <= (i >= 60 && i < 110);
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_voxel(1'b1, 16'($urandom),
                           (pick < 10) ? 8'($urandom) : 8'($urandom_range(0, 20)));
            else if (pick < 75)
            begin
                t = cur_thr[$urandom_range(0, 7)];
                t = t + 16'($urandom_range(0, 80)) - 16'd40;
                send_voxel(1'b0, t, 8'($urandom));
            end
            else if (pick < 90)
                send_voxel(1'b0, 16'($urandom_range(0, 5200)), 8'($urandom));
            else
                send_voxel(1'b0, 16'($urandom), 8'($urandom));
        end
        quiet <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] v [7];
        logic [15:0] dir_t [20];
        cur_thr = '{RST_CUTOFF, RST_WM_LOWER, RST_WM_UPPER, RST_WM_GM_CENTER,
                    RST_GM_LOWER, RST_CSF_LOWER, RST_GM_UPPER, RST_CSF_UPPER};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty bin, zero t1, top of range, every threshold and band
        send_voxel(1'b1, 16'd0, 8'd0);
        dir_t = '{16'd0, 16'd65535, 16'd200, 16'd1300, 16'd1350, 16'd1400, 16'd1900,
                  16'd2200, 16'd5000, 16'd700, 16'd1320, 16'd1380, 16'd1600, 16'd1950,
                  16'd2050, 16'd2150, 16'd3000, 16'd6000, 16'd5119, 16'd5120};
        foreach (dir_t[i])
            send_voxel(1'b0, dir_t[i], 8'hFF);
        send_voxel(1'b1, 16'hFFFF, 8'd35);
        send_voxel(1'b1, 16'd0, 8'd67);
        send_voxel(1'b1, 16'd0, 8'd255);
        send_voxel(1'b1, 16'd0, 8'd0);

        // defaults again with a long receiver hold-off
        hold_req <= 1'b1;
        random_voxels(PHASE_ITEMS);
        drain();

        // cutoff in the middle, narrow transitions
        v = '{16'd100, 16'd900, 16'd905, 16'd910, 16'd1500, 16'd1502, 16'd4000};
        load_thresholds(16'd1000, v);
        random_voxels(PHASE_ITEMS);
        drain();

        // extremes: everything at the top, then cutoff, lower edge and center at zero with wide bands
        v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_thresholds(16'hFFFF, v);
        random_voxels(40);
        drain();
        v = '{16'd0, 16'd30000, 16'd0, 16'd40000, 16'd50000, 16'd65535, 16'd65535};
        load_thresholds(16'd0, v);
        random_voxels(PHASE_ITEMS - 40);
        drain();

        // overlapping bands and centers outside the transition
        v = '{16'd50, 16'd3000, 16'd100, 16'd2000, 16'd1000, 16'd4000, 16'd2500};
        load_thresholds(16'd20, v);
        random_voxels(PHASE_ITEMS);
        drain();

        // random thresholds, sorted and unsorted
        for (int ph = 0; ph < 2; ph++)
        begin
            foreach (v[i])
                v[i] = (ph == 0) ? 16'($urandom_range(i * 800, i * 800 + 799))
                                 : 16'($urandom_range(0, 6000));
            load_thresholds(16'($urandom_range(0, 300)), v);
            random_voxels(PHASE_ITEMS);
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
